@@ design/ball_indexer_conveyor_control_macros.svh @@
// Assertion macros for the ball indexer conveyor control block.
// Included by the top level; needs a clk and an active-low rst_n in scope.
`ifndef BALL_INDEXER_CONVEYOR_CONTROL_MACROS_SVH
`define BALL_INDEXER_CONVEYOR_CONTROL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BICC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BICC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bicc_pkg.sv @@
// Shared types and constants for the ball indexer conveyor control block.
// No dependencies; imported by every module of the block.
package bicc_pkg;

  // Configuration port geometry: six 32-bit registers at byte address 4*i.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [2:0] REG_ADVANCE_DELAY = 3'd0;
  localparam logic [2:0] REG_PRE_DELAY     = 3'd1;
  localparam logic [2:0] REG_VERT_LEVEL    = 3'd2;
  localparam logic [2:0] REG_HORIZ_LEVEL   = 3'd3;
  localparam logic [2:0] REG_FEED_HORIZ    = 3'd4;
  localparam logic [2:0] REG_FEED_VERT     = 3'd5;

  // Reset values of the registers.
  localparam logic [15:0] ADVANCE_DELAY_RST = 16'd25;
  localparam logic [15:0] PRE_DELAY_RST     = 16'd0;
  localparam logic [14:0] VERT_LEVEL_RST    = 15'd16384;
  localparam logic [14:0] HORIZ_LEVEL_RST   = 15'd16384;

  // Saturation limits.
  localparam logic [2:0]  COUNT_MAX = 3'd7;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [15:0]        advance_delay;
    logic [15:0]        pre_delay;
    logic [14:0]        vert_level;
    logic [14:0]        horiz_level;
    logic signed [15:0] feed_horiz;
    logic signed [15:0] feed_vert;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic signed [15:0] vertical_drive;
    logic signed [15:0] horizontal_drive;
    logic [2:0]         balls_held;
  } result_t;

  // Internal state exposed for checking.
  typedef struct packed {
    logic [2:0] ball_total;
    logic       timer_active;
    logic       outtake_done;
  } status_t;

endpackage

@@ design/bicc_cfg.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on bicc_pkg for register indexes, reset values and cfg_t.
module bicc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bicc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bicc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bicc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output bicc_pkg::cfg_t                  cfg
);
  import bicc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ADVANCE_DELAY: cfg_nxt.advance_delay = pwdata[15:0];
        REG_PRE_DELAY:     cfg_nxt.pre_delay     = pwdata[15:0];
        REG_VERT_LEVEL:    cfg_nxt.vert_level    = pwdata[14:0];
        REG_HORIZ_LEVEL:   cfg_nxt.horiz_level   = pwdata[14:0];
        REG_FEED_HORIZ:    cfg_nxt.feed_horiz    = signed'(pwdata[15:0]);
        REG_FEED_VERT:     cfg_nxt.feed_vert     = signed'(pwdata[15:0]);
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.advance_delay <= ADVANCE_DELAY_RST;
      cfg_r.pre_delay     <= PRE_DELAY_RST;
      cfg_r.vert_level    <= VERT_LEVEL_RST;
      cfg_r.horiz_level   <= HORIZ_LEVEL_RST;
      cfg_r.feed_horiz    <= '0;
      cfg_r.feed_vert     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_ADVANCE_DELAY: prdata = {16'd0, cfg_r.advance_delay};
      REG_PRE_DELAY:     prdata = {16'd0, cfg_r.pre_delay};
      REG_VERT_LEVEL:    prdata = {17'd0, cfg_r.vert_level};
      REG_HORIZ_LEVEL:   prdata = {17'd0, cfg_r.horiz_level};
      REG_FEED_HORIZ:    prdata = {16'd0, cfg_r.feed_horiz};
      REG_FEED_VERT:     prdata = {16'd0, cfg_r.feed_vert};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ design/bicc_core.sv @@
// Per-tick control logic: ball count, tick timer, outtake flag and belt commands.
// Depends on bicc_pkg for cfg_t, result_t, status_t and the saturation limits.
module bicc_core #(
  parameter int BALL_LIMIT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 ball_seen,
  input  logic                 outtake_pressed,
  input  logic                 lift_pressed,
  input  logic                 shooting,
  input  logic                 manual_mode,
  input  logic                 auto_running,
  input  logic signed [15:0]   intake_axis,
  input  bicc_pkg::cfg_t       cfg,
  output bicc_pkg::result_t    result,
  output bicc_pkg::status_t    status
);
  import bicc_pkg::*;

  localparam logic [2:0] LIMIT = 3'(BALL_LIMIT);

  logic [2:0]  count_r, count_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        active_r, active_nxt;
  logic        done_r, done_nxt;

  logic [15:0]        elapsed_adv;
  logic [15:0]        elapsed_tmp;
  logic               active_tmp;
  logic [2:0]         count_mid;
  logic signed [15:0] vert_pos;
  logic signed [15:0] horiz_pos;
  logic signed [31:0] product;
  logic signed [15:0] horiz_scaled;
  logic signed [15:0] v_drive;
  logic signed [15:0] h_drive;

  function automatic logic [2:0] sat_inc(input logic [2:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 3'd1;
  endfunction

  // Level times axis, floor-shifted back to Q1.15; always fits 16 bits.
  assign product      = signed'({17'd0, cfg.horiz_level}) * 32'(intake_axis);
  assign horiz_scaled = product[30:15];
  assign vert_pos     = signed'({1'b0, cfg.vert_level});
  assign horiz_pos    = signed'({1'b0, cfg.horiz_level});

  // Timer advance at the start of the tick.
  assign elapsed_adv = (active_r && elapsed_r != TICKS_MAX) ? elapsed_r + 16'd1 : elapsed_r;

  // Next state and belt commands for one tick.
  always_comb begin
    count_mid   = count_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_adv;
    active_nxt  = active_r;
    done_nxt    = done_r;
    elapsed_tmp = elapsed_adv;
    active_tmp  = active_r;
    v_drive     = cfg.feed_vert;
    h_drive     = cfg.feed_horiz;
    if (!shooting) begin
      // Vertical belt, first match wins.
      priority if (outtake_pressed) begin
        v_drive  = -vert_pos;
        done_nxt = 1'b1;
      end else if (lift_pressed) begin
        v_drive = vert_pos;
      end else if (manual_mode || done_r) begin
        v_drive     = '0;
        count_mid   = '0;
        elapsed_nxt = '0;
        active_nxt  = 1'b0;
      end else begin
        if (count_r < LIMIT && ball_seen) begin
          elapsed_tmp = '0;
          active_tmp  = 1'b1;
        end
        if (elapsed_tmp > cfg.advance_delay) begin
          v_drive     = '0;
          count_mid   = sat_inc(count_r);
          elapsed_nxt = '0;
          active_nxt  = 1'b0;
        end else begin
          elapsed_nxt = elapsed_tmp;
          active_nxt  = active_tmp;
          v_drive     = (elapsed_tmp > cfg.pre_delay) ? vert_pos : 16'sd0;
        end
      end

      // Horizontal belt uses the count as updated above.
      priority if (outtake_pressed) begin
        h_drive = -horiz_pos;
      end else if (auto_running && count_mid <= LIMIT) begin
        h_drive = horiz_pos;
      end else if (count_mid <= LIMIT || manual_mode || done_nxt) begin
        h_drive = horiz_scaled;
      end else begin
        h_drive = '0;
      end

      // A ball seen at the limit still counts.
      count_nxt = (count_mid == LIMIT && ball_seen) ? sat_inc(count_mid) : count_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      elapsed_r <= '0;
      active_r  <= 1'b0;
      done_r    <= 1'b0;
    end else if (step) begin
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      active_r  <= active_nxt;
      done_r    <= done_nxt;
    end
  end

  assign result.vertical_drive   = v_drive;
  assign result.horizontal_drive = h_drive;
  assign result.balls_held       = count_nxt;

  assign status.ball_total   = count_r;
  assign status.timer_active = active_r;
  assign status.outtake_done = done_r;

endmodule

@@ design/bicc_skid.sv @@
// Two-entry result buffer: output register plus a skid register.
// Depends on bicc_pkg for result_t.
module bicc_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bicc_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bicc_pkg::result_t out_data
);
  import bicc_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign push_ready = !skid_vld_r;
  assign pop        = head_vld_r && out_ready;
  assign out_valid  = head_vld_r;
  assign out_data   = head_r;

  // Item movement between input, skid and head.
  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_nxt     = push_data;
        skid_vld_nxt = push;
      end else begin
        head_nxt     = push_data;
        head_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ design/ball_indexer_conveyor_control.sv @@
// Top level of the ball indexer conveyor control block.
// Depends on bicc_pkg, bicc_cfg, bicc_core, bicc_skid and the assertion macro header.
//
//   Channel  Handshake                        Payload
//   in       in_valid / in_ready              ball_seen .. intake_axis (7 fields)
//   out      out_valid / out_ready            vertical_drive, horizontal_drive, balls_held
//   cfg      psel, penable, pwrite / pready   paddr[4:2] register, pwdata / prdata
//
// One item is accepted per cycle while in_ready is high; its result reaches the output
// register at the next edge, or waits in the skid entry while that register is held by
// out_ready. The control state is updated in the same cycle the item is taken.
// Synchronous active-low reset clears control state, config registers and valid flags.
// A two-entry output buffer lets the input take one more item into the skid entry while
// out_ready is low; in_ready drops only when both entries are full.
`include "ball_indexer_conveyor_control_macros.svh"

module ball_indexer_conveyor_control #(
  parameter int BALL_LIMIT = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_ball_seen,
  input  logic                            in_outtake_pressed,
  input  logic                            in_lift_pressed,
  input  logic                            in_shooting,
  input  logic                            in_manual_mode,
  input  logic                            in_auto_running,
  input  logic signed [15:0]              in_intake_axis,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_vertical_drive,
  output logic signed [15:0]              out_horizontal_drive,
  output logic [2:0]                      out_balls_held,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bicc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bicc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bicc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bicc_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_data;
  status_t status;
  logic    in_fire;

  assign in_fire = in_valid && in_ready;

  // Register file.
  bicc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Control state and belt command logic.
  bicc_core #(
    .BALL_LIMIT (BALL_LIMIT)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (in_fire),
    .ball_seen       (in_ball_seen),
    .outtake_pressed (in_outtake_pressed),
    .lift_pressed    (in_lift_pressed),
    .shooting        (in_shooting),
    .manual_mode     (in_manual_mode),
    .auto_running    (in_auto_running),
    .intake_axis     (in_intake_axis),
    .cfg             (cfg),
    .result          (result),
    .status          (status)
  );

  // Result buffer.
  bicc_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_vertical_drive   = out_data.vertical_drive;
  assign out_horizontal_drive = out_data.horizontal_drive;
  assign out_balls_held       = out_data.balls_held;

  // After an accepted item, out_valid is always high on the next cycle.
  `BICC_ASSERT_NEXT(a_result_follows, in_fire, out_valid, "accepted item produced no result")
  // Manual mode with no button pressed empties the count and stops the timer.
  `BICC_ASSERT_NEXT(a_manual_clears,
    in_fire && !in_shooting && !in_outtake_pressed && !in_lift_pressed && in_manual_mode,
    status.ball_total == '0 && !status.timer_active, "manual mode did not clear count")
  // Shooting leaves the count and the outtake flag untouched.
  `BICC_ASSERT_NEXT(a_shoot_holds, in_fire && in_shooting,
    status.ball_total == $past(status.ball_total) &&
    status.outtake_done == $past(status.outtake_done), "shooting changed the count")
  // The outtake flag never clears once set.
  `BICC_ASSERT_NEXT(a_outtake_sticky, status.outtake_done, status.outtake_done,
    "outtake flag cleared")

endmodule
